### rtl/wrfsc_pkg.sv
// wrfsc_pkg: types, codes and helper functions for the receive frame sync capture block
// standalone package, used by rtl/wlan_rx_frame_sync_capture.sv
package wrfsc_pkg;

  // receiver synchronization states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SYNC = 2'd1,
    ST_WAIT = 2'd2,
    ST_GARB = 2'd3
  } sync_state_t;

  // input item operations
  typedef enum logic [1:0] {
    OP_PREAMBLE = 2'd0,
    OP_PAYLOAD  = 2'd1,
    OP_TRANSMIT = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  // result event kinds
  typedef enum logic [2:0] {
    EV_DELIVER = 3'd0,
    EV_START   = 3'd1,
    EV_END     = 3'd2,
    EV_ERROR   = 3'd3,
    EV_FAILED  = 3'd4,
    EV_RECORD  = 3'd5
  } event_kind_t;

  // configuration register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_DETECT   = 3'd0;
  localparam logic [2:0] REG_IDLE_CAP = 3'd1;
  localparam logic [2:0] REG_SYNC_CAP = 3'd2;
  localparam logic [2:0] REG_GARB_CAP = 3'd3;
  localparam logic [2:0] REG_ERR_UNSY = 3'd4;

  // sync machine context
  typedef struct packed {
    sync_state_t st;
    logic [47:0] addr;
    logic        addr_vld;
    logic [47:0] fend;
    logic [47:0] tmo;
    logic        tmo_arm;
    logic [2:0]  frag;
  } sync_ctx_t;

  // one result item
  typedef struct packed {
    event_kind_t kind;
    logic [23:0] dur;
    logic [9:0]  sinr;
    logic [47:0] addr;
    logic        last;
  } out_item_t;

  // events produced by one input item
  typedef struct packed {
    out_item_t [2:0] ev;
    logic [1:0]      n;
  } ev_list_t;

  function automatic out_item_t mk_item(event_kind_t k, logic [23:0] dur,
                                        logic [9:0] sinr, logic [47:0] addr);
    out_item_t e;
    e.kind = k;
    e.dur  = dur;
    e.sinr = sinr;
    e.addr = addr;
    e.last = 1'b0;
    return e;
  endfunction

  // append an event, at most three kept
  function automatic ev_list_t push_ev(ev_list_t l, out_item_t e);
    ev_list_t r;
    r = l;
    if (r.n != 2'd3) begin
      r.ev[r.n] = e;
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

  // drop the synced transmitter
  function automatic sync_ctx_t clear_sync(sync_ctx_t c);
    sync_ctx_t r;
    r = c;
    r.addr     = '0;
    r.addr_vld = 1'b0;
    r.frag     = '0;
    return r;
  endfunction

  // timeout expiry; the caller emits rx_end when leaving synchronized
  function automatic sync_ctx_t fire_timeout(sync_ctx_t c, logic [47:0] now,
                                             logic [47:0] now_fd);
    sync_ctx_t r;
    r = c;
    if (c.st == ST_SYNC) begin
      r.st      = ST_WAIT;
      r.tmo     = now_fd;
      r.tmo_arm = 1'b1;
    end else begin
      if (c.fend > now) begin
        r.st      = ST_GARB;
        r.tmo     = c.fend;
        r.tmo_arm = 1'b1;
      end else begin
        r.st      = ST_IDLE;
        r.tmo_arm = 1'b0;
      end
      r = clear_sync(r);
    end
    return r;
  endfunction

  // enter garbled, extending the frame end if this frame runs longer
  function automatic sync_ctx_t go_garbled(sync_ctx_t c, logic [47:0] frame_end);
    sync_ctx_t r;
    r = c;
    if (frame_end > c.fend) begin
      r.fend    = frame_end;
      r.tmo     = frame_end;
      r.tmo_arm = 1'b1;
    end else if (!c.tmo_arm) begin
      r.tmo     = c.fend;
      r.tmo_arm = 1'b1;
    end
    r    = clear_sync(r);
    r.st = ST_GARB;
    return r;
  endfunction

endpackage

### rtl/wlan_rx_frame_sync_capture.sv
// wlan_rx_frame_sync_capture: receiver frame sync state machine with event output queue
// depends on wrfsc_pkg (rtl/wrfsc_pkg.sv)

// Takes one receive item (preamble, payload, local transmit or time tick) per
// cycle into an input register while the held item can move on to the output
// queue, resolves it combinationally against the sync context and loads its zero
// to three events into a three-entry output queue. The input register and then
// the output queue lie between an accepted item and its results on the output
// port. The next item is resolved in the same cycle that its predecessor's last
// event leaves the queue, so one item's events can be loaded while the last
// event of the previous one is taken; results leave one at a time through the single output port.
// Times are 48-bit nanoseconds, saturating at the top; SINR values are quarter dB.
module wlan_rx_frame_sync_capture #(
  parameter int FINAL_DELIVERY_NS   = 10,
  parameter int EXTEND_TOLERANCE_NS = 1000
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input item stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // now_ns[47:0], sinr_qdb[57:48], crc_ok[58], frame_duration_ns[82:59],
  // transmitter_address[130:83], stream_count[133:131], zero fill [135:134]
  input  logic [135:0]               in_tdata,
  // operation[1:0]
  input  logic [1:0]                 in_tuser,
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // event_duration_ns[23:0], record_sinr_qdb[33:24], record_address[81:34],
  // state_after[83:82], zero fill [87:84]
  output logic [87:0]                out_tdata,
  // event_kind[2:0]
  output logic [2:0]                 out_tuser,
  output logic                       out_tlast,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import wrfsc_pkg::*;

  // configuration registers
  logic signed [9:0] det_thr_r, idle_cap_r, sync_cap_r, garb_cap_r;
  logic              err_unsync_r;

  // input register stage
  logic              in_vld_r;
  op_t               in_op_r;
  logic [47:0]       in_now_r;
  logic signed [9:0] in_sinr_r;
  logic              in_crc_r;
  logic [23:0]       in_dur_r;
  logic [47:0]       in_addr_r;
  logic [2:0]        in_streams_r;
  logic [47:0]       in_end_r;
  logic [48:0]       in_now_fd_r;

  logic [48:0]       sum_end;
  logic [48:0]       sum_fd;

  // sync context and output queue
  sync_ctx_t         ctx_r, ctx_nxt;
  out_item_t [2:0]   obuf_r;
  logic [1:0]        cnt_r;
  sync_state_t       st_out_r;

  logic              buf_free;
  logic              proc_fire;
  logic              out_hs;
  logic              cfg_wr;

  ev_list_t          evl;
  logic signed [9:0] thr;
  logic [47:0]       now_fd_sat;
  logic [47:0]       fend_diff;
  logic              ext_ok;
  logic              pay_match;

  // handshakes
  assign out_hs    = out_tvalid && out_tready;
  assign buf_free  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);
  assign proc_fire = in_vld_r && buf_free;
  assign in_tready = !in_vld_r || proc_fire;
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_thr_r    <= 10'sd16;
      idle_cap_r   <= 10'sd16;
      sync_cap_r   <= 10'sd40;
      garb_cap_r   <= 10'sd40;
      err_unsync_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_DETECT:   det_thr_r    <= pwdata[9:0];
        REG_IDLE_CAP: idle_cap_r   <= pwdata[9:0];
        REG_SYNC_CAP: sync_cap_r   <= pwdata[9:0];
        REG_GARB_CAP: garb_cap_r   <= pwdata[9:0];
        REG_ERR_UNSY: err_unsync_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // configuration readback
  always_comb begin
    unique case (paddr[4:2])
      REG_DETECT:   prdata = {{22{det_thr_r[9]}}, det_thr_r};
      REG_IDLE_CAP: prdata = {{22{idle_cap_r[9]}}, idle_cap_r};
      REG_SYNC_CAP: prdata = {{22{sync_cap_r[9]}}, sync_cap_r};
      REG_GARB_CAP: prdata = {{22{garb_cap_r[9]}}, garb_cap_r};
      REG_ERR_UNSY: prdata = {31'd0, err_unsync_r};
      default:      prdata = 32'd0;
    endcase
  end

  // time sums prepared on the way in
  assign sum_end = {1'b0, in_tdata[47:0]} + {25'd0, in_tdata[82:59]};
  assign sum_fd  = {1'b0, in_tdata[47:0]} + 49'(FINAL_DELIVERY_NS);

  // input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r      <= op_t'(in_tuser[1:0]);
      in_now_r     <= in_tdata[47:0];
      in_sinr_r    <= in_tdata[57:48];
      in_crc_r     <= in_tdata[58];
      in_dur_r     <= in_tdata[82:59];
      in_addr_r    <= in_tdata[130:83];
      in_streams_r <= in_tdata[133:131];
      in_end_r     <= sum_end[48] ? {48{1'b1}} : sum_end[47:0];
      in_now_fd_r  <= sum_fd;
    end
  end

  // side terms for the resolve step
  assign now_fd_sat = in_now_fd_r[48] ? {48{1'b1}} : in_now_fd_r[47:0];
  assign fend_diff  = ctx_r.fend - in_end_r;
  assign ext_ok     = (in_end_r >= ctx_r.fend) ||
                      (fend_diff < 48'(EXTEND_TOLERANCE_NS));
  assign pay_match  = ((ctx_r.st == ST_SYNC) || (ctx_r.st == ST_WAIT)) &&
                      ctx_r.addr_vld && (in_addr_r == ctx_r.addr);

  // capture threshold for the current state
  always_comb begin
    unique case (ctx_r.st)
      ST_IDLE: thr = idle_cap_r;
      ST_GARB: thr = garb_cap_r;
      default: thr = sync_cap_r;
    endcase
  end

  // next sync context and event list for the registered item
  always_comb begin
    ctx_nxt = ctx_r;
    evl     = '0;
    if (in_vld_r) begin
      unique case (in_op_r)
        OP_PREAMBLE: begin
          if (!(in_sinr_r < det_thr_r)) begin
            if ((ctx_r.st == ST_SYNC) && ctx_r.addr_vld && (in_addr_r == ctx_r.addr)) begin
              // further spatial stream fragment from the synced sender
              if (in_streams_r == ctx_r.frag + 3'd1) begin
                ctx_nxt.frag = ctx_r.frag + 3'd1;
                evl = push_ev(evl, mk_item(EV_DELIVER, '0, '0, '0));
              end
            end else if (in_streams_r <= 3'd1) begin
              if (in_sinr_r > thr) begin
                if (ctx_r.st == ST_SYNC) begin
                  evl = push_ev(evl, mk_item(EV_ERROR, '0, '0, '0));
                end
                if (in_crc_r) begin
                  evl = push_ev(evl, mk_item(EV_START, in_dur_r, '0, '0));
                  ctx_nxt.tmo     = in_end_r;
                  ctx_nxt.tmo_arm = 1'b1;
                  if (ext_ok) begin
                    ctx_nxt.fend = in_end_r;
                  end
                  ctx_nxt.addr     = in_addr_r;
                  ctx_nxt.addr_vld = 1'b1;
                  ctx_nxt.st       = ST_SYNC;
                  ctx_nxt.frag     = 3'd1;
                  evl = push_ev(evl, mk_item(EV_DELIVER, '0, '0, '0));
                end else begin
                  ctx_nxt = go_garbled(ctx_r, in_end_r);
                end
              end else if ((ctx_r.st == ST_SYNC) || (ctx_r.st == ST_WAIT)) begin
                // too weak to capture: only stretch the busy medium
                if (in_end_r > ctx_r.fend) begin
                  ctx_nxt.fend = in_end_r;
                end
              end else begin
                ctx_nxt = go_garbled(ctx_r, in_end_r);
              end
            end
          end
        end
        OP_PAYLOAD: begin
          if (pay_match) begin
            if (in_crc_r) begin
              evl = push_ev(evl, mk_item(EV_RECORD, '0, in_sinr_r, in_addr_r));
              if (({1'b0, ctx_r.fend} < in_now_fd_r) && (ctx_r.st == ST_SYNC)) begin
                evl = push_ev(evl, mk_item(EV_END, '0, '0, '0));
                ctx_nxt.tmo_arm = 1'b0;
                ctx_nxt = fire_timeout(ctx_nxt, in_now_r, now_fd_sat);
              end
              evl = push_ev(evl, mk_item(EV_DELIVER, '0, '0, '0));
            end else begin
              evl = push_ev(evl, mk_item(EV_ERROR, '0, '0, '0));
            end
          end else if (err_unsync_r) begin
            evl = push_ev(evl, mk_item(EV_ERROR, '0, '0, '0));
          end
          // final delivery of the synced frame closes the wait
          if ((ctx_nxt.st == ST_WAIT) && ctx_nxt.addr_vld &&
              (in_addr_r == ctx_nxt.addr)) begin
            ctx_nxt.tmo_arm = 1'b0;
            ctx_nxt = fire_timeout(ctx_nxt, in_now_r, now_fd_sat);
          end
        end
        OP_TRANSMIT: begin
          if (ctx_r.st != ST_IDLE) begin
            if (ctx_r.st == ST_SYNC) begin
              evl = push_ev(evl, mk_item(EV_ERROR, '0, '0, '0));
            end
            ctx_nxt.fend    = in_now_r;
            ctx_nxt.tmo_arm = 1'b0;
            ctx_nxt.st      = ST_IDLE;
            ctx_nxt = clear_sync(ctx_nxt);
          end
        end
        OP_TICK: begin
          if (ctx_r.tmo_arm && (in_now_r >= ctx_r.tmo)) begin
            if (ctx_r.st == ST_SYNC) begin
              evl = push_ev(evl, mk_item(EV_END, '0, '0, '0));
            end
            ctx_nxt.tmo_arm = 1'b0;
            ctx_nxt = fire_timeout(ctx_nxt, in_now_r, now_fd_sat);
          end
        end
        default: ;
      endcase
    end
    // mark the final event of the item
    evl.ev[0].last = (evl.n == 2'd1);
    evl.ev[1].last = (evl.n == 2'd2);
    evl.ev[2].last = (evl.n == 2'd3);
  end

  // sync context register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r <= '{st: ST_IDLE, addr: '0, addr_vld: 1'b0, fend: '0, tmo: '0,
                 tmo_arm: 1'b0, frag: '0};
    end else if (proc_fire) begin
      ctx_r <= ctx_nxt;
    end
  end

  // output queue fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (proc_fire) begin
      cnt_r <= evl.n;
    end else if (out_hs) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  // output queue entries, head at index 0
  always_ff @(posedge clk) begin
    if (proc_fire) begin
      obuf_r   <= evl.ev;
      st_out_r <= ctx_nxt.st;
    end else if (out_hs) begin
      obuf_r[0] <= obuf_r[1];
      obuf_r[1] <= obuf_r[2];
    end
  end

  // result port
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tuser  = obuf_r[0].kind;
  assign out_tlast  = obuf_r[0].last;
  assign out_tdata  = {4'd0, st_out_r, obuf_r[0].addr, obuf_r[0].sinr, obuf_r[0].dur};

`ifndef SYNTHESIS
  // the head item is last exactly when it is the only one left
  a_last_at_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (cnt_r == 2'd1)))
    else $error("last flag does not match queue fill");

  // a timeout is pending in every state but idle
  a_armed_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.tmo_arm == (ctx_r.st != ST_IDLE))
    else $error("timeout arm out of step with sync state");

  // a synced transmitter exists only while synchronized or waiting
  a_addr_vld_state: assert property (@(posedge clk) disable iff (!rst_n)
    ctx_r.addr_vld == ((ctx_r.st == ST_SYNC) || (ctx_r.st == ST_WAIT)))
    else $error("synced address validity out of step with sync state");

  // fragment count is cleared whenever no transmitter is held
  a_frag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !ctx_r.addr_vld |-> (ctx_r.frag == 3'd0))
    else $error("fragment count left over without a synced sender");

  // an item is only resolved when the output queue is free for it
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r > 2'd1) |=> (cnt_r != 2'd0) && ((cnt_r == $past(cnt_r)) ||
                        (cnt_r == $past(cnt_r) - 2'd1)))
    else $error("output queue overwritten while draining");
`endif

endmodule

### verif/tb_wlan_rx_frame_sync_capture.sv
// testbench for wlan_rx_frame_sync_capture: directed and random receive traffic,
// a self-checking event scoreboard and apb register phases
// depends on wrfsc_pkg (rtl/wrfsc_pkg.sv) and rtl/wlan_rx_frame_sync_capture.sv
`timescale 1ns / 100ps

module tb_wlan_rx_frame_sync_capture;
  import wrfsc_pkg::*;

  localparam int FINAL_NS      = 10;
  localparam int TOLERANCE_NS  = 1000;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [47:0] TMAX   = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] PEER_A = 48'h0123_4567_89AB;
  localparam logic [47:0] PEER_B = 48'hFEDC_BA98_7654;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [135:0] in_tdata;
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [87:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [4:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // one expected result item
  typedef struct {
    event_kind_t  kind;
    logic [23:0]  dur;
    logic [9:0]   sinr;
    logic [47:0]  addr;
    sync_state_t  state;
    logic         last;
  } rx_event_t;

  // sync machine tracker: predicts the events of each accepted item and checks results
  class sync_capture_tracker;
    logic signed [9:0] detect_thr, idle_cap, sync_cap, garb_cap;
    bit                err_unsynced;
    sync_state_t       st;
    logic [47:0]       peer_addr;
    bit                peer_vld;
    logic [47:0]       frame_end;
    logic [47:0]       tmo_at;
    bit                tmo_arm;
    logic [2:0]        frag;
    rx_event_t         expected_events[$];
    rx_event_t         item_events[$];
    int                n_errors;
    int                n_items;
    int                n_results;
    int                kind_seen[6];

    function new();
      detect_thr   = 10'sd16;
      idle_cap     = 10'sd16;
      sync_cap     = 10'sd40;
      garb_cap     = 10'sd40;
      err_unsynced = 1'b0;
      st           = ST_IDLE;
      peer_addr    = '0;
      peer_vld     = 1'b0;
      frame_end    = '0;
      tmo_at       = '0;
      tmo_arm      = 1'b0;
      frag         = '0;
      n_errors     = 0;
      n_items      = 0;
      n_results    = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic signed [9:0] val);
      case (idx)
        REG_DETECT:   detect_thr = val;
        REG_IDLE_CAP: idle_cap = val;
        REG_SYNC_CAP: sync_cap = val;
        REG_GARB_CAP: garb_cap = val;
        REG_ERR_UNSY: err_unsynced = val[0];
        default: ;
      endcase
    endfunction

    // time plus duration, clipped at the top of the 48-bit range
    function logic [47:0] end_time(logic [47:0] t, logic [47:0] d);
      logic [48:0] s;
      s = {1'b0, t} + {1'b0, d};
      return s[48] ? TMAX : s[47:0];
    endfunction

    function void add(event_kind_t k, logic [23:0] d, logic [9:0] s, logic [47:0] a);
      rx_event_t e;
      if (item_events.size() >= 3) return;
      e.kind  = k;
      e.dur   = d;
      e.sinr  = s;
      e.addr  = a;
      e.state = ST_IDLE;
      e.last  = 1'b0;
      item_events.push_back(e);
    endfunction

    function void drop_peer();
      peer_addr = '0;
      peer_vld  = 1'b0;
      frag      = '0;
    endfunction

    // timeout expiry at time now
    function void expire(logic [47:0] now);
      if (st == ST_SYNC) begin
        add(EV_END, '0, '0, '0);
        st      = ST_WAIT;
        tmo_at  = end_time(now, 48'(FINAL_NS));
        tmo_arm = 1'b1;
        return;
      end
      if (frame_end > now) begin
        st      = ST_GARB;
        tmo_at  = frame_end;
        tmo_arm = 1'b1;
      end else begin
        st      = ST_IDLE;
        tmo_arm = 1'b0;
      end
      drop_peer();
    endfunction

    function void enter_garbled(logic [47:0] now, logic [23:0] dur);
      logic [47:0] fe;
      fe = end_time(now, {24'd0, dur});
      if (fe > frame_end) begin
        frame_end = fe;
        tmo_at    = fe;
        tmo_arm   = 1'b1;
      end else if (!tmo_arm) begin
        tmo_at  = frame_end;
        tmo_arm = 1'b1;
      end
      drop_peer();
      st = ST_GARB;
    endfunction

    function void note_input(op_t op, logic [47:0] now, logic signed [9:0] sinr, bit crc,
                             logic [23:0] dur, logic [47:0] addr, logic [2:0] streams);
      logic signed [9:0] thr;
      logic [47:0]       fe;
      logic [2:0]        nxt;
      bit                match;
      item_events.delete();
      n_items++;
      case (op)
        OP_PREAMBLE: begin
          nxt = frag + 3'd1;
          if (sinr < detect_thr) begin
            // too weak to detect
          end else if (st == ST_SYNC && peer_vld && addr == peer_addr) begin
            // next spatial stream fragment of the synced frame
            if (streams == nxt) begin
              frag = nxt;
              add(EV_DELIVER, '0, '0, '0);
            end
          end else if (streams <= 3'd1) begin
            case (st)
              ST_IDLE: thr = idle_cap;
              ST_GARB: thr = garb_cap;
              default: thr = sync_cap;
            endcase
            if (sinr > thr) begin
              if (st == ST_SYNC) add(EV_ERROR, '0, '0, '0);
              if (crc) begin
                fe = end_time(now, {24'd0, dur});
                add(EV_START, dur, '0, '0);
                tmo_at  = fe;
                tmo_arm = 1'b1;
                if (fe >= frame_end || (frame_end - fe) < 48'(TOLERANCE_NS)) frame_end = fe;
                peer_addr = addr;
                peer_vld  = 1'b1;
                st        = ST_SYNC;
                frag      = 3'd1;
                add(EV_DELIVER, '0, '0, '0);
              end else begin
                enter_garbled(now, dur);
              end
            end else if (st == ST_SYNC || st == ST_WAIT) begin
              fe = end_time(now, {24'd0, dur});
              if (fe > frame_end) frame_end = fe;
            end else begin
              enter_garbled(now, dur);
            end
          end
        end
        OP_PAYLOAD: begin
          match = (st == ST_SYNC || st == ST_WAIT) && peer_vld && addr == peer_addr;
          if (match) begin
            if (crc) begin
              add(EV_RECORD, '0, sinr, addr);
              // frame ends within final delivery time: close it early
              if ({1'b0, frame_end} < {1'b0, now} + 49'(FINAL_NS) && st == ST_SYNC) begin
                tmo_arm = 1'b0;
                expire(now);
              end
              add(EV_DELIVER, '0, '0, '0);
            end else begin
              add(EV_ERROR, '0, '0, '0);
            end
          end else if (err_unsynced) begin
            add(EV_ERROR, '0, '0, '0);
          end
          if (st == ST_WAIT && peer_vld && addr == peer_addr) begin
            tmo_arm = 1'b0;
            expire(now);
          end
        end
        OP_TRANSMIT: begin
          if (st != ST_IDLE) begin
            if (st == ST_SYNC) add(EV_ERROR, '0, '0, '0);
            frame_end = now;
            tmo_arm   = 1'b0;
            st        = ST_IDLE;
            drop_peer();
          end
        end
        default: begin
          if (tmo_arm && now >= tmo_at) begin
            tmo_arm = 1'b0;
            expire(now);
          end
        end
      endcase
      foreach (item_events[i]) begin
        item_events[i].state = st;
        item_events[i].last  = (i == item_events.size() - 1);
        expected_events.push_back(item_events[i]);
      end
    endfunction

    function void check_result(logic [2:0] kind, logic [87:0] data, logic last);
      rx_event_t e;
      n_results++;
      if (kind < 3'd6) kind_seen[kind]++;
      if (expected_events.size() == 0) begin
        $error("result with nothing expected: event_kind %0d", kind);
        n_errors++;
        return;
      end
      e = expected_events.pop_front();
      if (kind !== e.kind) begin
        $error("event_kind: expected %0d, got %0d", e.kind, kind);
        n_errors++;
      end
      if (data[23:0] !== e.dur) begin
        $error("event_duration_ns: expected %0d, got %0d", e.dur, data[23:0]);
        n_errors++;
      end
      if (data[33:24] !== e.sinr) begin
        $error("record_sinr_qdb: expected %h, got %h", e.sinr, data[33:24]);
        n_errors++;
      end
      if (data[81:34] !== e.addr) begin
        $error("record_address: expected %h, got %h", e.addr, data[81:34]);
        n_errors++;
      end
      if (data[83:82] !== e.state) begin
        $error("state_after: expected %0d, got %0d", e.state, data[83:82]);
        n_errors++;
      end
      if (last !== e.last) begin
        $error("last_event: expected %0d, got %0d", e.last, last);
        n_errors++;
      end
    endfunction
  endclass

  sync_capture_tracker tracker;
  logic [47:0] clock_ns;
  logic [47:0] peers[4];
  int          items_sent;
  int          n_settings;
  int          cycles;
  bit          tx_lazy;
  bit          rx_lazy;

  wlan_rx_frame_sync_capture #(
    .FINAL_DELIVERY_NS   (FINAL_NS),
    .EXTEND_TOLERANCE_NS (TOLERANCE_NS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // switch between randomly throttled and full-rate stretches on both sides
  initial begin
    tx_lazy = 1'b1;
    rx_lazy = 1'b1;
    forever begin
      repeat ($urandom_range(40, 250)) @(posedge clk);
      tx_lazy = ($urandom_range(0, 2) != 0);
      rx_lazy = ($urandom_range(0, 2) != 0);
    end
  end

  // result side: random stalls, check each accepted item
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = rx_lazy ? $urandom_range(0, 5) : 0;
      @(negedge clk);
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      tracker.check_result(out_tuser, out_tdata, out_tlast);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [23:0] pick_duration();
    return ($urandom_range(0, 9) == 0) ? 24'($urandom) : 24'($urandom_range(0, 3000));
  endfunction

  function automatic logic [9:0] strong_sinr();
    return ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 511));
  endfunction

  task automatic send_item(input op_t op, input logic [47:0] now, input logic [9:0] sinr,
                           input bit crc, input logic [23:0] dur, input logic [47:0] addr,
                           input logic [2:0] streams);
    int gap;
    gap = tx_lazy ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = op;
    in_tdata  = {2'b00, streams, addr, dur, crc, sinr, now};
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_input(op, now, sinr, crc, dur, addr, streams);
    items_sent++;
  endtask

  // wait until all results are in, then let a no-result item settle
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic signed [9:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = {{22{val[9]}}, val};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input logic signed [9:0] det, input logic signed [9:0] idl,
                           input logic signed [9:0] syn, input logic signed [9:0] garb,
                           input bit err);
    write_reg(REG_DETECT, det);
    write_reg(REG_IDLE_CAP, idl);
    write_reg(REG_SYNC_CAP, syn);
    write_reg(REG_GARB_CAP, garb);
    write_reg(REG_ERR_UNSY, {9'd0, err});
    n_settings++;
  endtask

  task automatic send_noise();
    op_t         op;
    logic [47:0] now;
    logic [47:0] addr;
    op   = op_t'($urandom_range(0, 3));
    now  = ($urandom_range(0, 15) == 0) ? rand48() : clock_ns;
    addr = ($urandom_range(0, 1) == 0) ? rand48() : peers[2'($urandom_range(0, 3))];
    send_item(op, now, 10'($urandom), 1'($urandom), pick_duration(), addr, 3'($urandom));
  endtask

  // mostly complete frame exchanges from a few peers, the rest noise
  task automatic random_traffic(input int count);
    int          stop_at;
    int          nfrag;
    logic [47:0] a;
    logic [47:0] t0;
    logic [23:0] d;
    stop_at  = items_sent + count;
    peers[0] = rand48();
    peers[1] = rand48();
    peers[2] = TMAX;
    peers[3] = '0;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        send_noise();
      end else begin
        a        = peers[2'($urandom_range(0, 3))];
        d        = pick_duration();
        clock_ns = clock_ns + 48'($urandom_range(20, 400));
        t0       = clock_ns;
        send_item(OP_PREAMBLE, clock_ns, strong_sinr(), $urandom_range(0, 7) != 0, d, a,
                  ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'd1);
        // further spatial stream fragments, occasionally out of order
        nfrag = $urandom_range(0, 3);
        for (int k = 2; k <= nfrag + 1; k++) begin
          clock_ns = clock_ns + 48'($urandom_range(0, 40));
          send_item(OP_PREAMBLE, clock_ns, strong_sinr(), 1'b1, d, a,
                    ($urandom_range(0, 4) == 0) ? 3'($urandom) : 3'(k));
        end
        if ($urandom_range(0, 3) == 0) send_noise();
        repeat ($urandom_range(1, 3)) begin
          clock_ns = clock_ns + 48'($urandom_range(0, 300));
          send_item(OP_PAYLOAD, clock_ns, 10'($urandom), $urandom_range(0, 4) != 0, '0, a,
                    3'($urandom));
        end
        // run into the frame end, then the final delivery window
        if ($urandom_range(0, 3) != 0) begin
          if (t0 + {24'd0, d} > clock_ns) clock_ns = t0 + {24'd0, d};
          clock_ns = clock_ns + 48'($urandom_range(0, 5));
          send_item(OP_TICK, clock_ns, '0, 1'b0, '0, '0, 3'd1);
          clock_ns = clock_ns + 48'($urandom_range(0, 15));
          if ($urandom_range(0, 2) != 0)
            send_item(OP_PAYLOAD, clock_ns, 10'($urandom), 1'b1, '0, a, 3'd1);
          clock_ns = clock_ns + 48'($urandom_range(5, 30));
          send_item(OP_TICK, clock_ns, '0, 1'b0, '0, '0, 3'd1);
        end
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_TICK;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    clock_ns   = '0;
    items_sent = 0;
    n_settings = 1;
    cycles     = 0;
    tracker    = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part with reset thresholds
    send_item(OP_TICK,     48'd0,    10'sd0,    1'b0, 24'd0,    '0,     3'd1);
    send_item(OP_PREAMBLE, 48'd1000, 10'sd100,  1'b1, 24'd5000, PEER_A, 3'd1);
    send_item(OP_PREAMBLE, 48'd1100, 10'sd100,  1'b1, 24'd5000, PEER_A, 3'd2);
    // repeated fragment number is dropped
    send_item(OP_PREAMBLE, 48'd1110, 10'sd100,  1'b1, 24'd5000, PEER_A, 3'd2);
    // foreign multi-stream preamble is dropped
    send_item(OP_PREAMBLE, 48'd1200, 10'sd300,  1'b1, 24'd5000, PEER_B, 3'd2);
    // weak foreign preamble stretches the frame end
    send_item(OP_PREAMBLE, 48'd1200, 10'sd20,   1'b1, 24'd8000, PEER_B, 3'd1);
    send_item(OP_PAYLOAD,  48'd1300, 10'sd50,   1'b0, 24'd0,    PEER_A, 3'd1);
    send_item(OP_PAYLOAD,  48'd5995, 10'sd77,   1'b1, 24'd0,    PEER_A, 3'd1);
    send_item(OP_TICK,     48'd6000, 10'sd0,    1'b0, 24'd0,    '0,     3'd1);
    send_item(OP_PAYLOAD,  48'd6005, 10'sd77,   1'b1, 24'd0,    PEER_A, 3'd1);
    send_item(OP_PREAMBLE, 48'd6100, 10'sd30,   1'b1, 24'd4000, PEER_B, 3'd1);
    send_item(OP_TRANSMIT, 48'd7000, 10'sd0,    1'b0, 24'd0,    '0,     3'd1);
    // zero duration, stream count zero, strongest sinr
    send_item(OP_PREAMBLE, 48'd7100, 10'sd511,  1'b1, 24'd0,    PEER_B, 3'd0);
    // capture while synced: rx_error, rx_start and deliver
    send_item(OP_PREAMBLE, 48'd7200, 10'sd511,  1'b1, 24'hFFFFFF, PEER_A, 3'd1);
    send_item(OP_TRANSMIT, 48'd7300, 10'sd0,    1'b0, 24'd0,    '0,     3'd1);
    send_item(OP_PREAMBLE, 48'd7350, -10'sd512, 1'b1, 24'd100,  PEER_A, 3'd1);
    send_item(OP_PREAMBLE, 48'd7400, 10'sd17,   1'b0, 24'd1000, PEER_A, 3'd1);
    send_item(OP_PAYLOAD,  48'd7500, 10'sd17,   1'b1, 24'd0,    PEER_B, 3'd1);
    send_item(OP_TICK,     TMAX,     10'sd0,    1'b0, 24'd0,    '0,     3'd1);
    // saturated frame end at the top of time
    send_item(OP_PREAMBLE, TMAX - 1, 10'sd100,  1'b1, 24'hFFFFFF, TMAX, 3'd1);
    send_item(OP_PAYLOAD,  TMAX,     -10'sd1,   1'b1, 24'd0,    TMAX,   3'd7);
    send_item(OP_TRANSMIT, TMAX,     10'sd0,    1'b0, 24'd0,    '0,     3'd1);
    send_item(OP_PREAMBLE, 48'd100,  10'sd100,  1'b1, 24'd100,  '0,     3'd1);
    send_item(OP_TRANSMIT, 48'd200,  10'sd0,    1'b0, 24'd0,    '0,     3'd1);
    clock_ns = 48'd1000;

    // open detection, idle and garbled thresholds, no capture while synced, errors for unsynced payloads
    wait_idle();
    configure(-10'sd512, -10'sd512, 10'sd511, -10'sd512, 1'b1);
    random_traffic(35);

    // moderate thresholds; sender holds off mid-way until results drain
    wait_idle();
    configure(10'sd0, 10'sd20, 10'sd60, 10'sd30, 1'b0);
    random_traffic(25);
    wait_idle();
    random_traffic(25);

    // nearly everything below detection
    wait_idle();
    configure(10'sd511, 10'sd511, -10'sd512, 10'sd511, 1'b1);
    random_traffic(10);

    // easy capture while synced
    wait_idle();
    configure(-10'sd100, 10'sd100, -10'sd512, 10'sd0, 1'b1);
    random_traffic(45);

    wait_idle();
    if (tracker.expected_events.size() != 0) begin
      $error("%0d expected results never arrived", tracker.expected_events.size());
      tracker.n_errors++;
    end
    $display("covered %0d items over %0d register settings, %0d results checked",
             tracker.n_items, n_settings, tracker.n_results);
    $display("results by kind: deliver %0d, rx_start %0d, rx_end %0d, rx_error %0d, record %0d",
             tracker.kind_seen[EV_DELIVER], tracker.kind_seen[EV_START],
             tracker.kind_seen[EV_END], tracker.kind_seen[EV_ERROR],
             tracker.kind_seen[EV_RECORD]);
    if (tracker.n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### wlan_rx_frame_sync_capture.f
rtl/wrfsc_pkg.sv
rtl/wlan_rx_frame_sync_capture.sv
verif/tb_wlan_rx_frame_sync_capture.sv
